// ===== hdl/clts_pkg.sv =====
// Package for the character LCD text terminal: item types, sizes, command
// codes, sequencer states and the serial frame encoder.
// No dependencies.
`timescale 1ns / 1ps

package clts_pkg;

  // Display geometry.
  localparam int LINE_WIDTH = 20;
  localparam int LINES      = 4;
  localparam int DEPTH      = LINES * LINE_WIDTH;
  localparam int COL_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = 3;   // logical rows 0..3 plus "past the last line"
  localparam int INI_W      = 3;

  // Request kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [7:0] CHAR_NL    = 8'd10;

  // Display commands.
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] START_CMD  = 8'hF8;
  localparam logic [7:0] START_DATA = 8'hFA;
  localparam logic [INI_W-1:0] INI_LAST = INI_W'(4);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [23:0] first_frame;
    logic        second_present;
    logic [23:0] second_frame;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request
    ST_CHR,    // send one character and store it at the cursor
    ST_NL,     // newline: select the next line
    ST_CLR,    // clear display and store
    ST_INI,    // init command sequence
    ST_SCL,    // scroll: clear the display
    ST_SEL,    // scroll: select a line
    ST_RD      // scroll: redraw one line from the store
  } state_t;

  // Start byte, then the bit-reversed data split into two nibble bytes.
  function automatic logic [23:0] enc_frame(input logic rs, input logic [7:0] d);
    logic [7:0] rev;
    for (int b = 0; b < 8; b++) begin
      rev[7-b] = d[b];
    end
    return {(rs ? START_DATA : START_CMD), rev[7:4], 4'b0000, rev[3:0], 4'b0000};
  endfunction

  function automatic logic [7:0] line_cmd(input logic [1:0] row);
    logic [7:0] cmd;
    case (row)
      2'd0:    cmd = 8'h80;
      2'd1:    cmd = 8'hA0;
      2'd2:    cmd = 8'hC0;
      default: cmd = 8'hE0;
    endcase
    return cmd;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [INI_W-1:0] idx);
    logic [7:0] cmd;
    case (idx)
      INI_W'(0): cmd = 8'h3C;
      INI_W'(1): cmd = 8'h09;
      INI_W'(2): cmd = 8'h38;
      INI_W'(3): cmd = 8'h0C;
      default:   cmd = 8'h01;
    endcase
    return cmd;
  endfunction

  // The store is a ring of lines: logical line plus the base line gives the
  // physical line, so a scroll only moves the base.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [1:0] row,
                                                  input logic [1:0] base,
                                                  input logic [COL_W-1:0] col);
    logic [1:0] prow;
    prow = row + base;
    return ADDR_W'(int'(prow) * LINE_WIDTH + int'(col));
  endfunction

endpackage

// ===== hdl/clts_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module clts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/char_lcd_terminal_scroll_top.sv =====
// Top level of the character LCD text terminal with scrolling.
// Depends on clts_pkg and clts_ram.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data) takes one request: write a
// character, clear the display and store, or run the init sequence. The
// output channel (out_valid, out_stall, out_data) returns the display
// commands as 24-bit serial frames, up to two per result item, and marks the
// final item of each request with last_of_run. Unused kind codes are accepted
// and produce nothing.
// One request is processed at a time; in_stall is high until its last frame
// has been handed to the output stage. A scroll sends a clear, the select and
// text of three redrawn lines and the select of the last line, then the
// character that caused it, if any, one frame per cycle while the output
// does not stall; a redrawn line ends at its first zero byte, which sends no
// frame. The rate is set by the single read port of the line store, which
// yields one redrawn character per cycle.
// The line store lives in a synchronous RAM. Per-entry valid flip-flops,
// cleared at once, make unwritten entries read as zero, so reset and the
// clear request need no sweep of the RAM.
// Reset (rst_n low, synchronous) empties the output stage, homes the cursor
// and invalidates the whole store. A stall on the output holds the result
// register and halts the sequencer once the pairing stage is full or the frame is final.

module char_lcd_terminal_scroll_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clts_pkg::out_item_t out_data
);

  import clts_pkg::*;

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic             nl_r, nl_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       base_r, base_nxt;
  logic [1:0]       rrow_r, rrow_nxt;
  logic [COL_W-1:0] rcol_r, rcol_nxt;
  logic [INI_W-1:0] ini_r, ini_nxt;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             vldq_r;

  // Store access.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        ram_q;
  logic [7:0]        rd_byte;

  // Frame produced by the sequencer this cycle.
  logic        frm_vld;
  logic        frm_rs;
  logic [7:0]  frm_byte;
  logic        frm_last;
  logic        frm_rdy;
  logic        frm_acc;
  logic [23:0] frm_word;

  // Pairing and output stage.
  logic        pend_vld_r, pend_vld_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_free;

  logic in_acc;
  logic rcol_end;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rd_byte  = vldq_r ? ram_q : 8'h00;
  assign rcol_end = (rcol_r == COL_W'(LINE_WIDTH - 1));

  assign out_free = !out_vld_r || !out_stall;
  // A lone non-final frame can always park in the pairing register.
  assign frm_rdy  = (!pend_vld_r && !frm_last) || out_free;
  assign frm_acc  = frm_vld && frm_rdy;
  assign frm_word = enc_frame(frm_rs, frm_byte);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            KIND_WRITE: begin
              if (in_data.char_code == CHAR_NL) begin
                // A newline on the last line, or past it, scrolls.
                state_nxt = (row_r >= ROW_W'(LINES - 1)) ? ST_SCL : ST_NL;
              end else begin
                state_nxt = (row_r == ROW_W'(LINES)) ? ST_SCL : ST_CHR;
              end
            end
            KIND_CLEAR: state_nxt = ST_CLR;
            KIND_INIT:  state_nxt = ST_INI;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CHR, ST_NL, ST_CLR: begin
        if (frm_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INI: begin
        if (frm_acc && ini_r == INI_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCL: begin
        if (frm_acc) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (frm_acc) begin
          if (rrow_r == 2'(LINES - 1)) begin
            state_nxt = nl_r ? ST_IDLE : ST_CHR;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        // A zero byte ends the line without a frame.
        if (rd_byte == 8'h00 || (frm_acc && rcol_end)) begin
          state_nxt = ST_SEL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Frame for the current state.
  always_comb begin
    frm_vld  = 1'b0;
    frm_rs   = 1'b0;
    frm_byte = 8'h00;
    frm_last = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_CHR: begin
        frm_vld  = 1'b1;
        frm_rs   = 1'b1;
        frm_byte = ch_r;
        frm_last = 1'b1;
      end
      ST_NL: begin
        frm_vld  = 1'b1;
        frm_byte = line_cmd(row_r[1:0] + 2'd1);
        frm_last = 1'b1;
      end
      ST_CLR: begin
        frm_vld  = 1'b1;
        frm_byte = CMD_CLEAR;
        frm_last = 1'b1;
      end
      ST_INI: begin
        frm_vld  = 1'b1;
        frm_byte = init_cmd(ini_r);
        frm_last = (ini_r == INI_LAST);
      end
      ST_SCL: begin
        frm_vld  = 1'b1;
        frm_byte = CMD_CLEAR;
      end
      ST_SEL: begin
        frm_vld  = 1'b1;
        frm_byte = line_cmd(rrow_r);
        frm_last = (rrow_r == 2'(LINES - 1)) && nl_r;
      end
      ST_RD: begin
        frm_vld  = (rd_byte != 8'h00);
        frm_rs   = 1'b1;
        frm_byte = rd_byte;
      end
      default: ;
    endcase
  end

  // Cursor, ring base, redraw position and valid bits. The store is only
  // written in ST_CHR and only read for the redraw in ST_RD, so a read and a
  // write never meet on the same entry.
  always_comb begin
    logic [1:0] clr_row;
    ch_nxt   = ch_r;
    nl_nxt   = nl_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    rrow_nxt = rrow_r;
    rcol_nxt = rcol_r;
    ini_nxt  = ini_r;
    vld_nxt  = vld_r;
    wr_en    = 1'b0;
    wr_addr  = phys_addr(row_r[1:0], base_r, col_r);
    clr_row  = 2'(LINES - 1);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ch_nxt   = in_data.char_code;
          nl_nxt   = (in_data.char_code == CHAR_NL);
          rrow_nxt = 2'd0;
          ini_nxt  = '0;
        end
      end
      ST_CHR: begin
        if (frm_acc) begin
          wr_en            = 1'b1;
          vld_nxt[wr_addr] = 1'b1;
          if (col_r == COL_W'(LINE_WIDTH - 1)) begin
            // Running off the end of a line enters the next one silently.
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end
      ST_NL: begin
        if (frm_acc) begin
          row_nxt = row_r + ROW_W'(1);
          col_nxt = '0;
        end
      end
      ST_CLR: begin
        if (frm_acc) begin
          vld_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      ST_INI: begin
        if (frm_acc) begin
          ini_nxt = ini_r + INI_W'(1);
        end
      end
      ST_SCL: begin
        if (frm_acc) begin
          // The old top line becomes the new, empty bottom line.
          base_nxt = base_r + 2'd1;
          for (int c = 0; c < LINE_WIDTH; c++) begin
            vld_nxt[phys_addr(clr_row, base_nxt, COL_W'(c))] = 1'b0;
          end
        end
      end
      ST_SEL: begin
        if (frm_acc) begin
          if (rrow_r == 2'(LINES - 1)) begin
            row_nxt = ROW_W'(LINES - 1);
            col_nxt = '0;
          end else begin
            rcol_nxt = '0;
          end
        end
      end
      ST_RD: begin
        if (rd_byte == 8'h00) begin
          rrow_nxt = rrow_r + 2'd1;
        end else if (frm_acc) begin
          if (rcol_end) begin
            rrow_nxt = rrow_r + 2'd1;
          end else begin
            rcol_nxt = rcol_r + COL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // The read address follows the next redraw position, so the registered read data matches the current one.
  assign rd_addr = phys_addr(rrow_nxt, base_r, rcol_nxt);

  // Pairing: frames go two to a result; a final frame flushes a lone one.
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && out_stall;
    if (frm_acc) begin
      if (pend_vld_r) begin
        out_nxt      = '{first_frame: pend_r, second_present: 1'b1,
                         second_frame: frm_word, last_of_run: frm_last};
        out_vld_nxt  = 1'b1;
        pend_vld_nxt = 1'b0;
      end else if (!frm_last) begin
        pend_nxt     = frm_word;
        pend_vld_nxt = 1'b1;
      end else begin
        out_nxt      = '{first_frame: frm_word, second_present: 1'b0,
                         second_frame: 24'h000000, last_of_run: 1'b1};
        out_vld_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      row_r      <= '0;
      col_r      <= '0;
      base_r     <= '0;
      rrow_r     <= '0;
      ini_r      <= '0;
      vld_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      base_r     <= base_nxt;
      rrow_r     <= rrow_nxt;
      ini_r      <= ini_nxt;
      vld_r      <= vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    nl_r   <= nl_nxt;
    rcol_r <= rcol_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    vldq_r <= vld_r[rd_addr];
  end

  clts_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ch_r),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== test/lcd_frame_check_pkg.sv =====
// Scoreboard for the character LCD text terminal: predicts the serial display
// frames of every accepted request and checks the returned results in order.
// Depends on clts_pkg for the item types, geometry and command codes.
`timescale 1ns / 1ps

package lcd_frame_check_pkg;
  import clts_pkg::*;

  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam logic [7:0] SEL_LINE_BASE   = 8'h80;
  localparam logic [7:0] SEL_LINE_STEP   = 8'h20;
  localparam logic [7:0] INIT_FUNC_EXT   = 8'h3C;
  localparam logic [7:0] INIT_EXT_MODE   = 8'h09;
  localparam logic [7:0] INIT_FUNC_BASIC = 8'h38;
  localparam logic [7:0] INIT_DISP_ON    = 8'h0C;
  localparam int         REPORT_LINES    = 60;

  class lcd_frame_scoreboard;
    logic [7:0]  text_mem [DEPTH];
    int unsigned cursor_pos;
    logic [23:0] frame_q [$];
    out_item_t   expected_q [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned requests_seen;
    int unsigned scrolls_seen;
    int unsigned longest_burst;

    function new();
      clear_text();
    endfunction

    function void clear_text();
      foreach (text_mem[i]) text_mem[i] = 8'h00;
      cursor_pos = 0;
    endfunction

    // Start byte by register select, then the bit-reversed byte split into
    // two nibbles, each in the upper half of its own byte.
    function void push_frame(bit is_data, logic [7:0] code);
      logic [7:0] flipped;
      flipped = {<<{code}};
      frame_q.push_back({(is_data ? START_DATA : START_CMD),
                         flipped[7:4], 4'h0, flipped[3:0], 4'h0});
    endfunction

    function void select_row(int unsigned row);
      push_frame(1'b0, SEL_LINE_BASE + 8'(SEL_LINE_STEP * row));
    endfunction

    function void scroll_up();
      logic [7:0] c;
      scrolls_seen++;
      push_frame(1'b0, CMD_CLEAR);
      for (int i = 0; i < (LINES - 1) * LINE_WIDTH; i++) text_mem[i] = text_mem[i + LINE_WIDTH];
      for (int row = 0; row < LINES - 1; row++) begin
        select_row(row);
        for (int col = 0; col < LINE_WIDTH; col++) begin
          c = text_mem[row * LINE_WIDTH + col];
          if (c == 8'h00) break;
          push_frame(1'b1, c);
        end
      end
      select_row(LINES - 1);
      for (int col = 0; col < LINE_WIDTH; col++) text_mem[(LINES - 1) * LINE_WIDTH + col] = 8'h00;
    endfunction

    function void put_char(logic [7:0] ch);
      bit          is_nl;
      int unsigned row;
      is_nl = (ch == CHAR_NL);
      if (cursor_pos < DEPTH) begin
        row = cursor_pos / LINE_WIDTH;
        if (is_nl) begin
          if (row + 1 < LINES) select_row(row + 1);
          cursor_pos = (row + 1) * LINE_WIDTH;
        end else begin
          text_mem[cursor_pos] = ch;
        end
      end
      if (cursor_pos >= DEPTH) begin
        scroll_up();
        if (!is_nl) text_mem[(LINES - 1) * LINE_WIDTH] = ch;
        cursor_pos = (LINES - 1) * LINE_WIDTH;
      end
      if (!is_nl) begin
        push_frame(1'b1, ch);
        cursor_pos++;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned n;
      frame_q.delete();
      case (req.kind)
        KIND_WRITE: put_char(req.char_code);
        KIND_CLEAR: begin
          push_frame(1'b0, CMD_CLEAR);
          clear_text();
        end
        KIND_INIT: begin
          push_frame(1'b0, INIT_FUNC_EXT);
          push_frame(1'b0, INIT_EXT_MODE);
          push_frame(1'b0, INIT_FUNC_BASIC);
          push_frame(1'b0, INIT_DISP_ON);
          push_frame(1'b0, CMD_CLEAR);
        end
        default: ;
      endcase
      if (req.kind != KIND_UNUSED) requests_seen++;
      // Frames leave in pairs; an odd tail goes out alone.
      n = (frame_q.size() + 1) / 2;
      if (n > longest_burst) longest_burst = n;
      for (int k = 0; k < n; k++) begin
        res.first_frame    = frame_q[2 * k];
        res.second_present = (2 * k + 1) < frame_q.size();
        res.second_frame   = res.second_present ? frame_q[2 * k + 1] : 24'h0;
        res.last_of_run    = (k == n - 1);
        expected_q.push_back(res);
      end
    endfunction

    function void report_mismatch(string what, logic [23:0] want, logic [23:0] got);
      mismatches++;
      if (mismatches <= REPORT_LINES)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unrequested result", 24'h0, got.first_frame);
        return;
      end
      want = expected_q.pop_front();
      if (got.first_frame !== want.first_frame)
        report_mismatch("first_frame", want.first_frame, got.first_frame);
      if (got.second_present !== want.second_present)
        report_mismatch("second_present", 24'(want.second_present), 24'(got.second_present));
      if (got.second_frame !== want.second_frame)
        report_mismatch("second_frame", want.second_frame, got.second_frame);
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", 24'(want.last_of_run), 24'(got.last_of_run));
    endfunction
  endclass

endpackage

// ===== test/tb.sv =====
// Testbench for char_lcd_terminal_scroll_top: directed and random terminal
// requests, random idling on both channels, results checked by the scoreboard.
// Depends on clts_pkg, lcd_frame_check_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import clts_pkg::*;
  import lcd_frame_check_pkg::*;

  localparam int RANDOM_REQUESTS = 430;
  localparam int IDLE_PERCENT    = 7;
  // Far longer than a full scroll, so this only fires on a real hang.
  localparam int HANG_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int QUIET_FROM      = 150;
  localparam int QUIET_TO        = 260;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // While quiet is set neither side idles, so back-to-back traffic is seen.
  bit                  quiet;
  int unsigned         dead_cycles = 0;
  lcd_frame_scoreboard sb;

  char_lcd_terminal_scroll_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // The receiver stalls now and then; the stall changes only at falling edges.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Both handshakes are sampled at the rising edge. A result is checked
  // before a request accepted at the same edge is noted, which is safe since
  // no request can produce a result at the edge that accepts it. The same
  // block counts cycles without any handshake and ends a hung run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
      end
      if (dead_cycles >= HANG_LIMIT) begin
        $display("Timed out after %0d cycles without a handshake.", HANG_LIMIT);
        $display("char_lcd_terminal_scroll_top verification failed");
        $finish;
      end
    end
  end

  // Offers one request at a falling edge, after an optional random gap, and
  // holds it unchanged until the block takes it. Returns at a falling edge.
  task automatic send_request(input logic [1:0] kind, input logic [7:0] code);
    in_item_t req;
    req.kind      = kind;
    req.char_code = code;
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    logic [7:0]  ch;
    sb        = new();
    sent      = 0;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Init and clear carry char codes that must be ignored,
    // and the unused kind must produce nothing.
    send_request(KIND_INIT, 8'hFF);
    send_request(KIND_CLEAR, CHAR_NL);
    send_request(KIND_UNUSED, 8'hA5);
    // A zero byte heads line 0, the top line that the first scroll drops.
    send_request(KIND_WRITE, 8'h00);
    send_request(KIND_WRITE, 8'hFF);
    // Three newlines walk down to the last line.
    repeat (3) send_request(KIND_WRITE, CHAR_NL);
    // Fill the last line completely; the cursor leaves the store silently.
    for (int i = 0; i < LINE_WIDTH; i++) send_request(KIND_WRITE, 8'(8'h21 + 11 * i));
    // A newline with the cursor past the last line scrolls but stores nothing,
    // and the next character lands at the start of the last line.
    send_request(KIND_WRITE, CHAR_NL);
    send_request(KIND_WRITE, 8'h5A);

    // Random part. Most of it is text, including whole lines so that the
    // redraw of a scroll runs at full length and newlines fall right on a
    // line boundary. Clear, init and the unused kind are mixed in rarely.
    while (sent < RANDOM_REQUESTS) begin
      quiet = (sent >= QUIET_FROM) && (sent < QUIET_TO);
      pick  = $urandom_range(0, 99);
      if (pick < 55) begin
        run_len = $urandom_range(1, 25);
        repeat (run_len) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) ch = CHAR_NL;
          else if (pick < 12) ch = 8'h00;
          else if (pick < 25) ch = 8'($urandom_range(0, 255));
          else ch = 8'($urandom_range(8'h20, 8'h7E));
          send_request(KIND_WRITE, ch);
        end
        sent += run_len;
      end else if (pick < 75) begin
        repeat (LINE_WIDTH) begin
          do ch = 8'($urandom_range(1, 255)); while (ch == CHAR_NL);
          send_request(KIND_WRITE, ch);
        end
        sent += LINE_WIDTH;
        if ($urandom_range(0, 1) == 1) begin
          send_request(KIND_WRITE, CHAR_NL);
          sent++;
        end
      end else if (pick < 85) begin
        run_len = $urandom_range(1, 5);
        repeat (run_len) send_request(KIND_WRITE, CHAR_NL);
        sent += run_len;
      end else if (pick < 91) begin
        send_request(KIND_CLEAR, 8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 96) begin
        send_request(KIND_INIT, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        // Ignored by the block, so it does not count as a request.
        send_request(KIND_UNUSED, 8'($urandom_range(0, 255)));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain the outstanding results, then give the block time to show any
    // stray result it should not produce.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d terminal requests with %0d scrolls; %0d results checked, up to %0d per request.",
             sb.requests_seen, sb.scrolls_seen, sb.results_seen, sb.longest_burst);
    if (sb.mismatches == 0) begin
      $display("char_lcd_terminal_scroll_top verification clean");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("char_lcd_terminal_scroll_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/clts_pkg.sv
hdl/clts_ram.sv
hdl/char_lcd_terminal_scroll_top.sv
test/lcd_frame_check_pkg.sv
test/tb.sv
